// File: hw/rtl/snlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlp_pkg
// Shared types and constants of the suffixed number literal parser.
// ----------------------------------------------------------------------------
package snlp_pkg;

    localparam int VALUE_BITS = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_LH    = 8'h68;
    localparam logic [7:0] CH_UH    = 8'h48;

    localparam logic [3:0] HEX_TEN  = 4'd10;

    localparam int OK_DEC = 0;
    localparam int OK_BIN = 1;
    localparam int OK_HEX = 2;

    typedef enum logic [1:0] {
        KIND_DEC = 2'd0,
        KIND_BIN = 2'd1,
        KIND_HEX = 2'd2,
        KIND_BAD = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] value;
    } result_t;

    typedef struct packed {
        logic [3:0] hv;
        logic [2:0] ok;
        logic       is_minus;
        logic       sfx_dec;
        logic       sfx_bin;
        logic       sfx_hex;
        logic       last;
    } cls_t;

endpackage

// File: hw/rtl/snlp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlp_front
// Character classifier: digit value, per-base validity, sign and suffix marks.
// ----------------------------------------------------------------------------
module snlp_front (
    input  logic                 char_valid,
    output logic                 char_ready,
    input  snlp_pkg::char_t      char_data,
    output logic                 push_valid,
    input  logic                 push_ready,
    output snlp_pkg::cls_t       push_data
);
    import snlp_pkg::*;

    logic [3:0] hv;
    logic       is_hex;

    always_comb
    begin
        hv     = '0;
        is_hex = 1'b1;
        case (char_data.ch) inside
            [CH_0:CH_9]:   hv = 4'(char_data.ch - CH_0);
            [CH_UA:CH_UF]: hv = 4'(char_data.ch - CH_UA) + HEX_TEN;
            [CH_LA:CH_LF]: hv = 4'(char_data.ch - CH_LA) + HEX_TEN;
            default:       is_hex = 1'b0;
        endcase
    end

    always_comb
    begin
        push_data.hv          = hv;
        push_data.ok[OK_HEX]  = is_hex;
        push_data.ok[OK_DEC]  = is_hex && (hv < HEX_TEN);
        push_data.ok[OK_BIN]  = is_hex && (hv < 4'd2);
        push_data.is_minus    = (char_data.ch == CH_MINUS);
        push_data.sfx_dec     = (char_data.ch == CH_LD) || (char_data.ch == CH_UD);
        push_data.sfx_bin     = (char_data.ch == CH_LB) || (char_data.ch == CH_UB);
        push_data.sfx_hex     = (char_data.ch == CH_LH) || (char_data.ch == CH_UH);
        push_data.last        = char_data.last;
    end

    assign push_valid = char_valid;
    assign char_ready = push_ready;

endmodule

// File: hw/rtl/snlp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlp_queue
// Short FIFO of classified characters between classifier and accumulator.
// ----------------------------------------------------------------------------
module snlp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  snlp_pkg::cls_t       push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output snlp_pkg::cls_t       pop_data
);
    import snlp_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    cls_t                mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                push, pop;

    assign push_ready = (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/snlp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlp_back
// Accumulator: runs the three base values and validity flags, emits results.
// ----------------------------------------------------------------------------
module snlp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  snlp_pkg::cls_t       pop_data,
    output logic                 result_valid,
    input  logic                 result_ready,
    output snlp_pkg::result_t    result_data
);
    import snlp_pkg::*;

    logic [VALUE_BITS-1:0]        acc_dec_reg, acc_dec_next;
    logic [VALUE_BITS-1:0]        acc_bin_reg, acc_bin_next;
    logic [VALUE_BITS-1:0]        acc_hex_reg, acc_hex_next;
    logic                         at_start_reg, at_start_next;
    logic                         neg_reg, neg_next;
    logic [2:0]                   ok_reg, ok_next;
    logic                         out_valid_reg, out_valid_next;
    result_t                      out_data_reg, out_data_next;

    logic                         take;
    logic [VALUE_BITS-1:0]        hv_ext;
    logic [VALUE_BITS-1:0]        dec_step;
    logic [VALUE_BITS-1:0]        fin_acc;
    logic [VALUE_BITS-1:0]        fin_mag;
    logic signed [VALUE_BITS-1:0] fin_s;
    kind_t                        fin_kind;

    assign pop_ready    = !pop_data.last || !out_valid_reg || result_ready;
    assign take         = pop_valid && pop_ready;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    assign hv_ext   = {{(VALUE_BITS-4){1'b0}}, pop_data.hv};
    assign dec_step = (acc_dec_reg << 3) + (acc_dec_reg << 1) + hv_ext;

    always_comb
    begin
        fin_kind = KIND_BAD;
        fin_acc  = '0;
        if (pop_data.sfx_dec)
        begin
            if (!at_start_reg && ok_reg[OK_DEC])
            begin
                fin_kind = KIND_DEC;
                fin_acc  = acc_dec_reg;
            end
        end
        else if (pop_data.sfx_bin)
        begin
            if (!at_start_reg && ok_reg[OK_BIN])
            begin
                fin_kind = KIND_BIN;
                fin_acc  = acc_bin_reg;
            end
        end
        else if (pop_data.sfx_hex)
        begin
            if (!at_start_reg && ok_reg[OK_HEX])
            begin
                fin_kind = KIND_HEX;
                fin_acc  = acc_hex_reg;
            end
        end
        else if (at_start_reg && pop_data.is_minus)
        begin
            fin_kind = KIND_DEC;
        end
        else if (pop_data.ok[OK_DEC] && ok_reg[OK_DEC])
        begin
            fin_kind = KIND_DEC;
            fin_acc  = dec_step;
        end
        fin_mag = neg_reg ? (VALUE_BITS'(0) - fin_acc) : fin_acc;
        if (fin_kind == KIND_BAD)
        begin
            fin_mag = '0;
        end
        fin_s = signed'(fin_mag);
    end

    always_comb
    begin
        acc_dec_next   = acc_dec_reg;
        acc_bin_next   = acc_bin_reg;
        acc_hex_next   = acc_hex_reg;
        at_start_next  = at_start_reg;
        neg_next       = neg_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_data_next  = out_data_reg;
        if (take)
        begin
            if (pop_data.last)
            begin
                acc_dec_next        = '0;
                acc_bin_next        = '0;
                acc_hex_next        = '0;
                at_start_next       = 1'b1;
                neg_next            = 1'b0;
                ok_next             = '1;
                out_valid_next      = 1'b1;
                out_data_next.kind  = fin_kind;
                out_data_next.value = 32'(fin_s);
            end
            else
            begin
                at_start_next = 1'b0;
                if (at_start_reg && pop_data.is_minus)
                begin
                    neg_next = 1'b1;
                end
                else
                begin
                    acc_dec_next = dec_step;
                    acc_bin_next = (acc_bin_reg << 1) + hv_ext;
                    acc_hex_next = (acc_hex_reg << 4) | hv_ext;
                    ok_next      = ok_reg & pop_data.ok;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_dec_reg   <= '0;
            acc_bin_reg   <= '0;
            acc_hex_reg   <= '0;
            at_start_reg  <= 1'b1;
            neg_reg       <= 1'b0;
            ok_reg        <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_dec_reg   <= acc_dec_next;
            acc_bin_reg   <= acc_bin_next;
            acc_hex_reg   <= acc_hex_next;
            at_start_reg  <= at_start_next;
            neg_reg       <= neg_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// File: hw/rtl/suffixed_number_literal_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffixed_number_literal_parser
// Parses base-suffixed assembler number literals, one character per cycle when not stalled.
// A result is registered in the accumulator after its final character has passed through the queue.
// Throughput: 1 character per cycle, unless an unread result stalls a final character.
// A 2-entry queue decouples the classifier from the accumulator.
// Reset: asynchronous, active low; clears queue, accumulators and result valid.
// ----------------------------------------------------------------------------
module suffixed_number_literal_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_ready,
    input  snlp_pkg::char_t      char_data,
    output logic                 result_valid,
    input  logic                 result_ready,
    output snlp_pkg::result_t    result_data
);
    import snlp_pkg::*;

    logic q_push_valid, q_push_ready;
    logic q_pop_valid, q_pop_ready;
    cls_t q_tail, q_head;

    snlp_front u_front (
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_tail)
    );

    snlp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_tail),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_head)
    );

    snlp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (q_pop_valid),
        .pop_ready    (q_pop_ready),
        .pop_data     (q_head),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.kind == KIND_BAD) |-> (result_data.value == 32'd0))
        else $error("invalid literal carries a nonzero value");

    a_push_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push_valid && q_push_ready && !q_pop_valid) |=> q_pop_valid)
        else $error("queued transaction lost");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(q_pop_valid && q_pop_ready && q_head.last))
        else $error("result without a final character");

    a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !q_push_ready |-> q_pop_valid)
        else $error("queue full and empty at once");

endmodule
